// ===== src/tvl0_pkg.sv =====
`default_nettype none

package tvl0_pkg;

  // widths of the channel fields
  localparam int CMD_BITS    = 2;
  localparam int COORD_BITS  = 9;
  localparam int VALUE_BITS  = 16;
  localparam int SRC_BITS    = 3;
  localparam int COST_BITS   = 34;
  localparam int WEIGHT_BITS = 16;

  // lambda resets to 1.0 in Q4.12
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = 16'd4096;

  // cost of leaving the original value, in Q.12 units
  localparam int MISMATCH_COST = 4096;

  // candidate slots, also the chosen_source codes
  localparam int NUM_SLOTS = 5;
  typedef logic [SRC_BITS-1:0] slot_t;
  localparam slot_t SLOT_ORIG  = 3'd0;
  localparam slot_t SLOT_DOWN  = 3'd1;
  localparam slot_t SLOT_UP    = 3'd2;
  localparam slot_t SLOT_RIGHT = 3'd3;
  localparam slot_t SLOT_LEFT  = 3'd4;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_READ,
    ST_READ_CAP,
    ST_GATHER,
    ST_START,
    ST_EVAL,
    ST_WRITE,
    ST_FINISH
  } state_e;

  // sequencer to cost unit
  typedef struct packed {
    logic                 start;
    logic [NUM_SLOTS-1:0] present;
  } cu_req_t;

  // cost unit to sequencer
  typedef struct packed {
    logic  done;
    slot_t best_slot;
  } cu_rsp_t;

endpackage

`default_nettype wire

// ===== src/tvl0_if.sv =====
`default_nettype none

// command channel
interface tvl0_in_if import tvl0_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CMD_BITS-1:0]   command;
  logic [COORD_BITS-1:0] row;
  logic [COORD_BITS-1:0] column;
  logic [VALUE_BITS-1:0] pixel_value;

  modport source (output valid, command, row, column, pixel_value, input ready);
  modport sink   (input valid, command, row, column, pixel_value, output ready);
endinterface

// result channel
interface tvl0_out_if import tvl0_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] result_value;
  logic [SRC_BITS-1:0]   chosen_source;
  logic [COST_BITS-1:0]  best_cost;

  modport source (output valid, result_value, chosen_source, best_cost, input ready);
  modport sink   (input valid, result_value, chosen_source, best_cost, output ready);
endinterface

// smoothness weight write channel
interface tvl0_cfg_if import tvl0_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [WEIGHT_BITS-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== src/tvl0_ram.sv =====
`default_nettype none

module tvl0_ram #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/tvl0_cost_unit.sv =====
`default_nettype none

module tvl0_cost_unit import tvl0_pkg::*; #(
  parameter int PIXEL_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cu_req_t                req_i,
  input  wire logic [PIXEL_BITS-1:0]  cand_i [NUM_SLOTS],
  input  wire logic [WEIGHT_BITS-1:0] weight_i,
  output cu_rsp_t                     rsp_o,
  output logic [PIXEL_BITS+17:0]      cost_o
);

  // sum of four differences needs two extra bits, the weighted sum sixteen more
  localparam int SW = PIXEL_BITS + 2;
  localparam int CW = PIXEL_BITS + 18;

  logic                 busy_q;
  slot_t                iss_q;
  logic [NUM_SLOTS-1:0] pres_q;

  logic                  s1_valid_q, s1_pres_q, s1_mism_q;
  slot_t                 s1_slot_q;
  logic [SW-1:0]         s1_sum_q;
  logic                  s2_valid_q, s2_pres_q, s2_mism_q;
  slot_t                 s2_slot_q;
  logic [CW-1:0]         s2_prod_q;
  logic                  done_q;
  slot_t                 best_slot_q;
  logic [CW-1:0]         best_cost_q;

  logic [PIXEL_BITS-1:0] cur;
  logic [SW-1:0]         sum;
  logic [CW-1:0]         cst;

  // issue counter walks the five candidates, one per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && iss_q == SLOT_LEFT) begin
        busy_q <= 1'b0;
      end
      s1_valid_q <= busy_q;
      s2_valid_q <= s1_valid_q;
      done_q     <= s2_valid_q && s2_slot_q == SLOT_LEFT;
    end
  end

  // stage one: sum of distances from the current candidate to present neighbors
  always_comb begin
    cur = cand_i[iss_q];
    sum = '0;
    for (int k = 1; k < NUM_SLOTS; k++) begin
      if (pres_q[k]) begin
        sum = sum + SW'((cur >= cand_i[k]) ? (cur - cand_i[k]) : (cand_i[k] - cur));
      end
    end
  end

  // stage three: add mismatch cost
  assign cst = s2_prod_q + (s2_mism_q ? CW'(MISMATCH_COST) : '0);

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      iss_q  <= SLOT_ORIG;
      pres_q <= req_i.present;
    end else if (busy_q) begin
      iss_q <= iss_q + slot_t'(1);
    end
    s1_slot_q <= iss_q;
    s1_pres_q <= pres_q[iss_q];
    s1_mism_q <= cur != cand_i[SLOT_ORIG];
    s1_sum_q  <= sum;
    // stage two: weight times distance sum
    s2_slot_q <= s1_slot_q;
    s2_pres_q <= s1_pres_q;
    s2_mism_q <= s1_mism_q;
    s2_prod_q <= CW'(s1_sum_q) * CW'(weight_i);
    // first strict minimum wins, original always scored first
    if (s2_valid_q && s2_pres_q && (s2_slot_q == SLOT_ORIG || cst < best_cost_q)) begin
      best_cost_q <= cst;
      best_slot_q <= s2_slot_q;
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.best_slot = best_slot_q;
  assign cost_o          = best_cost_q;

endmodule

`default_nettype wire

// ===== src/tv_l0_pixel_coordinate_descent.sv =====
`default_nettype none

// Pixel-wise TV-L0 coordinate descent over two single-port image stores
// (original and estimate, ROWS x COLS words of PIXEL_BITS bits, no reset
// and no clearing pass; read a pixel only after loading it). One command at
// a time: a load writes both stores, a read fetches from the estimate
// store and a command outside the image returns an all-zero result. An
// update fetches the original from its store and the neighbors through the
// estimate store's single port, then starts the cost unit, which scores one
// candidate per cycle through a sum / multiply / compare pipe; then the
// best candidate is written back and handed to the output register once
// that is free. A new command is taken while a finished result waits there.
// smoothness_weight may be written only while no command is in flight.
module tv_l0_pixel_coordinate_descent import tvl0_pkg::*; #(
  parameter int ROWS       = 512,
  parameter int COLS       = 512,
  parameter int PIXEL_BITS = 16
) (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  tvl0_cfg_if.sink    cfg_i,
  tvl0_in_if.sink     in_i,
  tvl0_out_if.source  out_o
);

  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = PIXEL_BITS;
  localparam int CW    = PIXEL_BITS + 18;

  state_e state_q, state_d;

  logic [WEIGHT_BITS-1:0] weight_q;
  logic [AW-1:0]          addr_q;
  logic [NUM_SLOTS-1:0]   pres_q;
  logic [PW-1:0]          pix_q;
  slot_t                  cnt_q;
  logic [PW-1:0]          cand_q [NUM_SLOTS];
  logic [VALUE_BITS-1:0]  val_q;
  slot_t                  src_q;
  logic [COST_BITS-1:0]   cost_q;

  logic                   out_valid_q;
  logic [VALUE_BITS-1:0]  out_value_q;
  slot_t                  out_src_q;
  logic [COST_BITS-1:0]   out_cost_q;

  logic                   accept, in_range, out_free;
  slot_t                  iss_slot;
  logic [AW-1:0]          nb_addr;
  logic                   est_we, est_re, org_we, org_re;
  logic [AW-1:0]          est_addr;
  logic [PW-1:0]          est_wdata, est_rdata, org_rdata;
  cu_req_t                cu_req;
  cu_rsp_t                cu_rsp;
  logic [CW-1:0]          cu_cost;

  assign accept   = in_i.valid && in_i.ready;
  assign in_range = (int'(in_i.row) < ROWS) && (int'(in_i.column) < COLS);
  assign out_free = !out_valid_q || out_o.ready;
  assign iss_slot = cnt_q + slot_t'(1);

  // neighbor address for the slot being fetched
  always_comb begin
    case (iss_slot)
      SLOT_DOWN:  nb_addr = addr_q + AW'(COLS);
      SLOT_UP:    nb_addr = addr_q - AW'(COLS);
      SLOT_RIGHT: nb_addr = addr_q + AW'(1);
      default:    nb_addr = addr_q - AW'(1);
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!in_range) begin
            state_d = ST_FINISH;
          end else if (in_i.command == CMD_LOAD) begin
            state_d = ST_LOAD;
          end else if (in_i.command == CMD_UPDATE) begin
            state_d = ST_GATHER;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_LOAD:     state_d = ST_FINISH;
      ST_READ:     state_d = ST_READ_CAP;
      ST_READ_CAP: state_d = ST_FINISH;
      ST_GATHER: begin
        if (cnt_q == slot_t'(NUM_SLOTS - 1)) begin
          state_d = ST_START;
        end
      end
      ST_START: state_d = ST_EVAL;
      ST_EVAL: begin
        if (cu_rsp.done) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // store controls and handshake outputs
  always_comb begin
    in_i.ready     = 1'b0;
    est_we         = 1'b0;
    est_re         = 1'b0;
    est_addr       = addr_q;
    est_wdata      = pix_q;
    org_we         = 1'b0;
    org_re         = 1'b0;
    cu_req.start   = 1'b0;
    cu_req.present = pres_q;
    case (state_q)
      ST_IDLE: in_i.ready = 1'b1;
      ST_LOAD: begin
        est_we = 1'b1;
        org_we = 1'b1;
      end
      ST_READ: est_re = 1'b1;
      ST_GATHER: begin
        est_addr = nb_addr;
        est_re   = (cnt_q < slot_t'(NUM_SLOTS - 1)) && pres_q[iss_slot];
        org_re   = cnt_q == SLOT_ORIG;
      end
      ST_START: cu_req.start = 1'b1;
      ST_WRITE: begin
        est_we    = 1'b1;
        est_wdata = cand_q[cu_rsp.best_slot];
      end
      default: ;
    endcase
  end

  assign cfg_i.ready = 1'b1;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      weight_q    <= WEIGHT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        weight_q <= cfg_i.data;
      end
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          addr_q             <= AW'(in_i.row) * AW'(COLS) + AW'(in_i.column);
          pix_q              <= PW'(in_i.pixel_value);
          pres_q[SLOT_ORIG]  <= 1'b1;
          pres_q[SLOT_DOWN]  <= int'(in_i.row) + 1 < ROWS;
          pres_q[SLOT_UP]    <= in_i.row != '0;
          pres_q[SLOT_RIGHT] <= int'(in_i.column) + 1 < COLS;
          pres_q[SLOT_LEFT]  <= in_i.column != '0;
          cnt_q              <= SLOT_ORIG;
          val_q              <= '0;
          src_q              <= SLOT_ORIG;
          cost_q             <= '0;
        end
      end
      ST_LOAD:     val_q <= VALUE_BITS'(pix_q);
      ST_READ_CAP: val_q <= VALUE_BITS'(est_rdata);
      ST_GATHER: begin
        cnt_q <= cnt_q + slot_t'(1);
        // data for the slot fetched last cycle
        if (cnt_q != SLOT_ORIG) begin
          cand_q[cnt_q] <= pres_q[cnt_q] ? est_rdata : '0;
        end
        if (cnt_q == SLOT_DOWN) begin
          cand_q[SLOT_ORIG] <= org_rdata;
        end
      end
      ST_WRITE: begin
        val_q  <= VALUE_BITS'(cand_q[cu_rsp.best_slot]);
        src_q  <= cu_rsp.best_slot;
        cost_q <= COST_BITS'(cu_cost);
      end
      ST_FINISH: begin
        if (out_free) begin
          out_value_q <= val_q;
          out_src_q   <= src_q;
          out_cost_q  <= cost_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.result_value  = out_value_q;
  assign out_o.chosen_source = out_src_q;
  assign out_o.best_cost     = out_cost_q;

  tvl0_ram #(.DEPTH(DEPTH), .WIDTH(PW)) u_org (
    .clk_i   (clk_i),
    .we_i    (org_we),
    .re_i    (org_re),
    .addr_i  (addr_q),
    .wdata_i (pix_q),
    .rdata_o (org_rdata)
  );

  tvl0_ram #(.DEPTH(DEPTH), .WIDTH(PW)) u_est (
    .clk_i   (clk_i),
    .we_i    (est_we),
    .re_i    (est_re),
    .addr_i  (est_addr),
    .wdata_i (est_wdata),
    .rdata_o (est_rdata)
  );

  tvl0_cost_unit #(.PIXEL_BITS(PW)) u_cost (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (cu_req),
    .cand_i   (cand_q),
    .weight_i (weight_q),
    .rsp_o    (cu_rsp),
    .cost_o   (cu_cost)
  );

endmodule

`default_nettype wire

// ===== src/tvl0_checker.sv =====
`default_nettype none

module tvl0_checker import tvl0_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [SRC_BITS-1:0] chosen_source
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // source code names the original or one of four neighbors
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> chosen_source <= SLOT_LEFT)
    else $error("chosen_source out of range");

  // one command at a time: busy right after a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while busy");

  // a result never appears in the cycle right after a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result too early");

endmodule

bind tv_l0_pixel_coordinate_descent tvl0_checker u_tvl0_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (in_i.valid),
  .in_ready      (in_i.ready),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .chosen_source (out_o.chosen_source)
);

`default_nettype wire

// ===== sim/tvl0_descent_compare.sv =====
`timescale 1ns / 100ps

// watches the three channels, predicts every result and compares it
module tvl0_descent_compare import tvl0_pkg::*; #(
  parameter int ROWS = 512,
  parameter int COLS = 512
) (
  input  logic clk_i,
  input  logic rst_ni,
  tvl0_cfg_if  cfg_mon,
  tvl0_in_if   in_mon,
  tvl0_out_if  out_mon,
  output int   errors_o,
  output int   pending_o
);

  typedef struct {
    logic [VALUE_BITS-1:0] value;
    slot_t                 src;
    logic [COST_BITS-1:0]  cost;
  } pixel_result_t;

  // predicted image stores and lambda
  logic [VALUE_BITS-1:0]  noisy_px [int];
  logic [VALUE_BITS-1:0]  estimate_px [int];
  logic [WEIGHT_BITS-1:0] lambda_q12;

  pixel_result_t result_q [$];

  initial begin
    errors_o   = 0;
    pending_o  = 0;
    lambda_q12 = WEIGHT_RESET;
  end

  function automatic logic [63:0] abs_gap(logic [VALUE_BITS-1:0] a,
                                          logic [VALUE_BITS-1:0] b);
    return (a > b) ? 64'(a - b) : 64'(b - a);
  endfunction

  // applies one command to the predicted stores and returns its result
  function automatic pixel_result_t apply_command(logic [CMD_BITS-1:0] cmd, int r, int c,
                                                  logic [VALUE_BITS-1:0] pix);
    pixel_result_t         res;
    logic [VALUE_BITS-1:0] cand [NUM_SLOTS];
    bit                    present [NUM_SLOTS];
    logic [63:0]           sum;
    logic [63:0]           cst;
    logic [63:0]           best;
    slot_t                 pick;
    int                    at;
    res.value = '0;
    res.src   = SLOT_ORIG;
    res.cost  = '0;
    best      = '0;
    pick      = SLOT_ORIG;
    if (r >= ROWS || c >= COLS) return res;
    at = r * COLS + c;
    if (cmd == CMD_LOAD) begin
      noisy_px[at]    = pix;
      estimate_px[at] = pix;
      res.value       = pix;
    end else if (cmd == CMD_UPDATE) begin
      present[SLOT_ORIG]  = 1'b1;
      present[SLOT_DOWN]  = (r + 1 < ROWS);
      present[SLOT_UP]    = (r > 0);
      present[SLOT_RIGHT] = (c + 1 < COLS);
      present[SLOT_LEFT]  = (c > 0);
      cand[SLOT_ORIG]  = noisy_px[at];
      cand[SLOT_DOWN]  = present[SLOT_DOWN]  ? estimate_px[at + COLS] : '0;
      cand[SLOT_UP]    = present[SLOT_UP]    ? estimate_px[at - COLS] : '0;
      cand[SLOT_RIGHT] = present[SLOT_RIGHT] ? estimate_px[at + 1]    : '0;
      cand[SLOT_LEFT]  = present[SLOT_LEFT]  ? estimate_px[at - 1]    : '0;
      // score candidates in slot order, first strict minimum wins
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!present[i]) continue;
        sum = '0;
        for (int k = int'(SLOT_DOWN); k < NUM_SLOTS; k++)
          if (present[k]) sum += abs_gap(cand[i], cand[k]);
        cst = 64'(lambda_q12) * sum;
        if (cand[i] != cand[SLOT_ORIG]) cst += 64'(MISMATCH_COST);
        if (i == int'(SLOT_ORIG) || cst < best) begin
          best = cst;
          pick = slot_t'(i);
        end
      end
      res.value       = cand[pick];
      res.src         = pick;
      res.cost        = best[COST_BITS-1:0];
      estimate_px[at] = cand[pick];
    end else begin
      res.value = estimate_px[at];
    end
    return res;
  endfunction

  // weight writes, predictions and compares, all sampled at the rising edge
  always @(posedge clk_i) begin
    pixel_result_t want;
    if (!rst_ni) begin
      lambda_q12 = WEIGHT_RESET;
      result_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) lambda_q12 = cfg_mon.data;
      if (in_mon.valid && in_mon.ready)
        result_q.push_back(apply_command(in_mon.command, int'(in_mon.row),
                                         int'(in_mon.column), in_mon.pixel_value));
      if (out_mon.valid && out_mon.ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: result transaction with nothing expected: value %h src %0d cost %h",
                   $time, out_mon.result_value, out_mon.chosen_source, out_mon.best_cost);
          errors_o++;
        end else begin
          want = result_q.pop_front();
          if (out_mon.result_value !== want.value) begin
            $display("%0t: result_value expected %h actual %h",
                     $time, want.value, out_mon.result_value);
            errors_o++;
          end
          if (out_mon.chosen_source !== want.src) begin
            $display("%0t: chosen_source expected %0d actual %0d",
                     $time, want.src, out_mon.chosen_source);
            errors_o++;
          end
          if (out_mon.best_cost !== want.cost) begin
            $display("%0t: best_cost expected %h actual %h",
                     $time, want.cost, out_mon.best_cost);
            errors_o++;
          end
        end
      end
    end
    pending_o = result_q.size();
  end

endmodule

// ===== sim/tv_l0_pixel_coordinate_descent_test.sv =====
`timescale 1ns / 100ps

module tv_l0_pixel_coordinate_descent_test;
  import tvl0_pkg::*;

  localparam int IMG_ROWS = 512;
  localparam int IMG_COLS = 512;
  localparam int PATCH    = 4;
  localparam int PHASE_ITEMS = 100;
  // unused command code, answered as a read
  localparam logic [CMD_BITS-1:0] CMD_SPARE = 2'd3;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  tvl0_cfg_if cfg_bus ();
  tvl0_in_if  cmd_bus ();
  tvl0_out_if res_bus ();

  int errors;
  int pending;
  int items_sent;
  int stall_left;
  bit calm;
  bit narrow;
  logic [VALUE_BITS-1:0] base_val;
  bit loaded [int];

  always #2 clk_i = ~clk_i;

  tv_l0_pixel_coordinate_descent dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (cmd_bus),
    .out_o  (res_bus)
  );

  tvl0_descent_compare #(.ROWS(IMG_ROWS), .COLS(IMG_COLS)) u_compare (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_mon   (cfg_bus),
    .in_mon    (cmd_bus),
    .out_mon   (res_bus),
    .errors_o  (errors),
    .pending_o (pending)
  );

  // result side back-pressure in random bursts
  always @(negedge clk_i) begin
    if (calm) begin
      res_bus.ready = 1'b1;
    end else if (stall_left > 0) begin
      res_bus.ready = 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 4) == 0) begin
      res_bus.ready = 1'b0;
      stall_left = $urandom_range(0, 5);
    end else begin
      res_bus.ready = 1'b1;
    end
  end

  function automatic int px_key(int r, int c);
    return r * IMG_COLS + c;
  endfunction

  function automatic bit px_loaded(int r, int c);
    if (r < 0 || c < 0 || r >= IMG_ROWS || c >= IMG_COLS) return 1'b1;
    return loaded.exists(px_key(r, c));
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_value();
    if (narrow) return base_val + VALUE_BITS'($urandom_range(0, 7));
    return VALUE_BITS'($urandom());
  endfunction

  // one command transaction, with an optional gap before it
  task automatic send_cmd(logic [CMD_BITS-1:0] cmd, int r, int c,
                          logic [VALUE_BITS-1:0] pix);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      cmd_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_bus.command     = cmd;
    cmd_bus.row         = COORD_BITS'(r);
    cmd_bus.column      = COORD_BITS'(c);
    cmd_bus.pixel_value = pix;
    cmd_bus.valid       = 1'b1;
    @(posedge clk_i);
    while (!cmd_bus.ready) @(posedge clk_i);
    if (cmd == CMD_LOAD) loaded[px_key(r, c)] = 1'b1;
    items_sent++;
    @(negedge clk_i);
  endtask

  // update when the pixel and its neighbors are loaded, else load the first gap
  task automatic update_or_fill(int r, int c);
    if (!px_loaded(r, c)) send_cmd(CMD_LOAD, r, c, pick_value());
    else if (!px_loaded(r + 1, c)) send_cmd(CMD_LOAD, r + 1, c, pick_value());
    else if (!px_loaded(r - 1, c)) send_cmd(CMD_LOAD, r - 1, c, pick_value());
    else if (!px_loaded(r, c + 1)) send_cmd(CMD_LOAD, r, c + 1, pick_value());
    else if (!px_loaded(r, c - 1)) send_cmd(CMD_LOAD, r, c - 1, pick_value());
    else send_cmd(CMD_UPDATE, r, c, VALUE_BITS'($urandom()));
  endtask

  task automatic drain();
    cmd_bus.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // lambda is only written with nothing in flight
  task automatic write_weight(logic [WEIGHT_BITS-1:0] w);
    drain();
    cfg_bus.data  = w;
    cfg_bus.valid = 1'b1;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
  endtask

  // a patch of pixels anywhere in the image, loaded and then worked on
  task automatic run_patch(bit last);
    int r0;
    int c0;
    int r;
    int c;
    int dice;
    case ($urandom_range(0, 3))
      0:       r0 = 0;
      1:       r0 = IMG_ROWS - PATCH;
      default: r0 = $urandom_range(0, IMG_ROWS - PATCH);
    endcase
    case ($urandom_range(0, 3))
      0:       c0 = 0;
      1:       c0 = IMG_COLS - PATCH;
      default: c0 = $urandom_range(0, IMG_COLS - PATCH);
    endcase
    narrow   = ($urandom_range(0, 3) != 0);
    base_val = VALUE_BITS'($urandom_range(0, 65520));
    if (!last) calm = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < PATCH; i++)
      for (int j = 0; j < PATCH; j++)
        send_cmd(CMD_LOAD, r0 + i, c0 + j, pick_value());
    repeat (35) begin
      dice = $urandom_range(0, 99);
      r = r0 + $urandom_range(0, PATCH - 1);
      c = c0 + $urandom_range(0, PATCH - 1);
      if (dice < 60) begin
        update_or_fill(r, c);
      end else if (dice < 75) begin
        send_cmd($urandom_range(0, 1) ? CMD_READ : CMD_SPARE, r, c,
                 VALUE_BITS'($urandom()));
      end else if (dice < 90) begin
        send_cmd(CMD_LOAD, r, c, pick_value());
      end else begin
        // stray load anywhere with a full-range value
        send_cmd(CMD_LOAD, $urandom_range(0, IMG_ROWS - 1),
                 $urandom_range(0, IMG_COLS - 1), VALUE_BITS'($urandom()));
      end
    end
  endtask

  initial begin
    logic [WEIGHT_BITS-1:0] weights [6];
    int phase_start;
    cfg_bus.valid       = 1'b0;
    cfg_bus.data        = '0;
    cmd_bus.valid       = 1'b0;
    cmd_bus.command     = CMD_LOAD;
    cmd_bus.row         = '0;
    cmd_bus.column      = '0;
    cmd_bus.pixel_value = '0;
    res_bus.ready       = 1'b0;
    items_sent = 0;
    stall_left = 0;
    calm       = 1'b0;
    narrow     = 1'b0;
    base_val   = '0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // top-left block: corner, top edge, left edge and interior
    send_cmd(CMD_LOAD, 0, 0, 16'h0000);
    send_cmd(CMD_LOAD, 0, 1, 16'hFFFF);
    send_cmd(CMD_LOAD, 0, 2, 16'd100);
    send_cmd(CMD_LOAD, 1, 0, 16'h5555);
    send_cmd(CMD_LOAD, 1, 1, 16'hAAAA);
    send_cmd(CMD_LOAD, 1, 2, 16'd103);
    send_cmd(CMD_LOAD, 2, 0, 16'd7);
    send_cmd(CMD_LOAD, 2, 1, 16'd101);
    send_cmd(CMD_LOAD, 2, 2, 16'd102);
    send_cmd(CMD_UPDATE, 0, 0, 16'h0000);
    send_cmd(CMD_UPDATE, 0, 1, 16'hFFFF);
    send_cmd(CMD_UPDATE, 1, 0, 16'h0000);
    send_cmd(CMD_UPDATE, 1, 1, 16'hFFFF);
    send_cmd(CMD_UPDATE, 1, 1, 16'h0000);
    send_cmd(CMD_READ, 1, 1, 16'hFFFF);
    send_cmd(CMD_SPARE, 0, 1, 16'h0000);
    // bottom-right corner
    send_cmd(CMD_LOAD, IMG_ROWS - 1, IMG_COLS - 1, 16'hFFFF);
    send_cmd(CMD_LOAD, IMG_ROWS - 2, IMG_COLS - 1, 16'hFFFE);
    send_cmd(CMD_LOAD, IMG_ROWS - 1, IMG_COLS - 2, 16'h0001);
    send_cmd(CMD_UPDATE, IMG_ROWS - 1, IMG_COLS - 1, 16'h0000);
    send_cmd(CMD_READ, IMG_ROWS - 1, IMG_COLS - 1, 16'h0000);

    // random phases, each under its own lambda, the last without idling
    weights[0] = 16'h0000;
    weights[1] = 16'hFFFF;
    weights[2] = 16'h0001;
    weights[3] = WEIGHT_BITS'($urandom());
    weights[4] = WEIGHT_BITS'($urandom_range(0, 8191));
    weights[5] = WEIGHT_RESET;
    for (int p = 0; p < 6; p++) begin
      write_weight(weights[p]);
      if (p == 5) calm = 1'b1;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) run_patch(p == 5);
    end

    drain();
    repeat (40) @(negedge clk_i);
    if (errors == 0) $display("tv_l0_pixel_coordinate_descent_test: clean");
    else $display("tv_l0_pixel_coordinate_descent_test: errors");
    $finish;
  end

  // hang guard
  initial begin
    #2000000;
    $display("tv_l0_pixel_coordinate_descent_test: errors");
    $finish;
  end

endmodule
